// ----- design/ry420_pkg.sv -----
// Shared types and constants for the RGB to YCbCr 4:2:0 subsampler.
// Used by ry420_ctrl, ry420_dp and rgb_to_ycbcr420_subsampler; no dependencies.
package ry420_pkg;

  localparam int unsigned CfgDataWidth = 13;
  localparam int unsigned CfgIdxWidth  = 2;

  localparam logic [CfgIdxWidth-1:0] RegFrameWidth   = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegFrameHeight  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegMatrixSelect = 2'd2;

  localparam logic [CfgDataWidth-1:0] DimReset = 13'd2;

  // Luma weights in units of 1/10000
  localparam int unsigned WtScale = 10000;
  localparam int unsigned W709R   = 2126;
  localparam int unsigned W709G   = 7152;
  localparam int unsigned W709B   = 722;
  localparam int unsigned W601R   = 2990;
  localparam int unsigned W601G   = 5870;
  localparam int unsigned W601B   = 1140;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
    logic       end_of_frame;
    logic       dims_error;
  } result_t;

  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } rgb9_t;

  typedef struct packed {
    logic accept;
    logic load_sum;
    logic load_prod;
    logic load_out;
  } cmd_t;

endpackage

// ----- design/rgb_to_ycbcr420_subsampler.sv -----
// A result is registered after the sum, product and output states, later if the output stalls.
// Input stalls until the previous pixel is loaded for output; the controller steps one pixel
// at a time through line-store read, multiply and sum steps of the single datapath.
// Reset (rst_ni, async, active low): counters and pair sum clear, frame 2x2, BT.709;
// the line store has no reset and no clearing pass.
// Top level: configuration registers, ry420_ctrl and ry420_dp; depends on ry420_pkg.
module rgb_to_ycbcr420_subsampler #(
  parameter int unsigned MAX_WIDTH       = 4096,
  parameter int unsigned MAX_HEIGHT      = 4096,
  parameter int unsigned COEFF_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  ry420_pkg::pixel_t                   in_pld_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output ry420_pkg::result_t                  out_pld_o,
  input  logic                                cfg_we_i,
  input  logic [ry420_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [ry420_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  logic [ry420_pkg::CfgDataWidth-1:0] frame_width_q, frame_height_q;
  logic                               matrix_sel_q;
  ry420_pkg::cmd_t                    cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= ry420_pkg::DimReset;
      frame_height_q <= ry420_pkg::DimReset;
      matrix_sel_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ry420_pkg::RegFrameWidth: begin
          frame_width_q <= cfg_data_i;
        end
        ry420_pkg::RegFrameHeight: begin
          frame_height_q <= cfg_data_i;
        end
        ry420_pkg::RegMatrixSelect: begin
          matrix_sel_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  ry420_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  ry420_dp #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_pld_i       (in_pld_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .matrix_sel_i   (matrix_sel_q),
    .out_pld_o      (out_pld_o)
  );

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous pixel still in flight");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_pld_o.dims_error |-> out_pld_o.luma == 8'd0 &&
      !out_pld_o.chroma_valid && !out_pld_o.end_of_frame)
    else $error("dimension error result carries data");

  a_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_pld_o.chroma_valid |->
      out_pld_o.blue_diff == 8'd0 && out_pld_o.red_diff == 8'd0)
    else $error("chroma nonzero without chroma_valid");
`endif

endmodule

// ----- design/ry420_ctrl.sv -----
// Sequencing controller for the subsampler: input transfer, datapath steps, output register.
// Depends on ry420_pkg.
module ry420_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ry420_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_PROD,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.accept     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.load_sum   = (state_q == S_SUM);
    cmd_o.load_prod  = (state_q == S_PROD);
    cmd_o.load_out   = (state_q == S_OUT) && out_free;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        state_d = S_PROD;
      end
      S_PROD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = (out_valid_q && out_stall_i) || cmd_o.load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/ry420_dp.sv -----
// Datapath for the subsampler: counters, pair sums, line store, luma and chroma arithmetic.
// Depends on ry420_pkg; driven by ry420_ctrl commands.
module ry420_dp #(
  parameter int unsigned MAX_WIDTH       = 4096,
  parameter int unsigned MAX_HEIGHT      = 4096,
  parameter int unsigned COEFF_FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ry420_pkg::cmd_t                      cmd_i,
  input  ry420_pkg::pixel_t                    in_pld_i,
  input  logic [ry420_pkg::CfgDataWidth-1:0]   frame_width_i,
  input  logic [ry420_pkg::CfgDataWidth-1:0]   frame_height_i,
  input  logic                                 matrix_sel_i,
  output ry420_pkg::result_t                   out_pld_o
);

  localparam int unsigned FW         = COEFF_FRAC_BITS;
  localparam int unsigned CW         = $clog2(MAX_WIDTH);
  localparam int unsigned RW         = $clog2(MAX_HEIGHT);
  localparam int unsigned WEW        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HEW        = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned TW         = FW + 13;
  localparam int unsigned LSW        = FW + 11;
  localparam int unsigned LPW        = FW + 8;
  localparam int unsigned PW         = FW + 10;

  localparam logic [63:0] Scale2 = 64'(ry420_pkg::WtScale) * 64'd2;
  localparam logic [63:0] Dcb709 = 64'd2 * 64'(ry420_pkg::WtScale - ry420_pkg::W709B);
  localparam logic [63:0] Dcr709 = 64'd2 * 64'(ry420_pkg::WtScale - ry420_pkg::W709R);
  localparam logic [63:0] Dcb601 = 64'd2 * 64'(ry420_pkg::WtScale - ry420_pkg::W601B);
  localparam logic [63:0] Dcr601 = 64'd2 * 64'(ry420_pkg::WtScale - ry420_pkg::W601R);

  localparam logic [FW-1:0] Kr709 =
    FW'(((64'(ry420_pkg::W709R) << (FW + 1)) + 64'(ry420_pkg::WtScale)) / Scale2);
  localparam logic [FW-1:0] Kg709 =
    FW'(((64'(ry420_pkg::W709G) << (FW + 1)) + 64'(ry420_pkg::WtScale)) / Scale2);
  localparam logic [FW-1:0] Kb709 =
    FW'(((64'(ry420_pkg::W709B) << (FW + 1)) + 64'(ry420_pkg::WtScale)) / Scale2);
  localparam logic [FW-1:0] Kr601 =
    FW'(((64'(ry420_pkg::W601R) << (FW + 1)) + 64'(ry420_pkg::WtScale)) / Scale2);
  localparam logic [FW-1:0] Kg601 =
    FW'(((64'(ry420_pkg::W601G) << (FW + 1)) + 64'(ry420_pkg::WtScale)) / Scale2);
  localparam logic [FW-1:0] Kb601 =
    FW'(((64'(ry420_pkg::W601B) << (FW + 1)) + 64'(ry420_pkg::WtScale)) / Scale2);

  localparam logic [FW-1:0] Cbr709 =
    FW'(((64'(ry420_pkg::W709R) << (FW + 1)) + Dcb709) / (Dcb709 * 64'd2));
  localparam logic [FW-1:0] Cbg709 =
    FW'(((64'(ry420_pkg::W709G) << (FW + 1)) + Dcb709) / (Dcb709 * 64'd2));
  localparam logic [FW-1:0] Crg709 =
    FW'(((64'(ry420_pkg::W709G) << (FW + 1)) + Dcr709) / (Dcr709 * 64'd2));
  localparam logic [FW-1:0] Crb709 =
    FW'(((64'(ry420_pkg::W709B) << (FW + 1)) + Dcr709) / (Dcr709 * 64'd2));
  localparam logic [FW-1:0] Cbr601 =
    FW'(((64'(ry420_pkg::W601R) << (FW + 1)) + Dcb601) / (Dcb601 * 64'd2));
  localparam logic [FW-1:0] Cbg601 =
    FW'(((64'(ry420_pkg::W601G) << (FW + 1)) + Dcb601) / (Dcb601 * 64'd2));
  localparam logic [FW-1:0] Crg601 =
    FW'(((64'(ry420_pkg::W601G) << (FW + 1)) + Dcr601) / (Dcr601 * 64'd2));
  localparam logic [FW-1:0] Crb601 =
    FW'(((64'(ry420_pkg::W601B) << (FW + 1)) + Dcr601) / (Dcr601 * 64'd2));

  localparam logic [LSW-1:0] LumaHalf = LSW'(1) << (FW - 1);
  localparam logic [TW-1:0]  ChromaOff = TW'(514) << FW;

  function automatic logic [7:0] sat_u8(input logic [10:0] v);
    sat_u8 = (v > 11'd255) ? 8'd255 : v[7:0];
  endfunction

  // Frame position and pair state
  logic [CW-1:0]        col_q;
  logic [RW-1:0]        row_q;
  ry420_pkg::rgb9_t     pair_q, pair_d;
  logic [WEW-1:0]       w_eff;
  logic [HEW-1:0]       h_eff;
  logic                 dims_odd, col_last, row_last, in_range;
  logic [AW-1:0]        addr;

  ry420_pkg::rgb9_t     line_mem [LINE_DEPTH];
  ry420_pkg::rgb9_t     top_q;

  ry420_pkg::pixel_t    pix_q;
  logic                 err_q, cv_q, eof_q;

  logic [9:0]           sr_q, sg_q, sb_q;
  logic [FW+7:0]        lpr_q, lpg_q, lpb_q;
  logic [FW+9:0]        pcbr_q, pcbg_q, pcrg_q, pcrb_q;
  logic [7:0]           luma_q;
  ry420_pkg::result_t   out_q;

  logic [FW-1:0]        kr, kg, kb, cbr, cbg, crg, crb;
  logic [LSW-1:0]       lsum;
  logic [TW-1:0]        tcb, tcr;
  logic [7:0]           cb, cr;

  always_comb begin
    if (frame_width_i < ry420_pkg::DimReset) begin
      w_eff = WEW'(2);
    end else if (32'(frame_width_i) > MAX_WIDTH) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(frame_width_i);
    end
    if (frame_height_i < ry420_pkg::DimReset) begin
      h_eff = HEW'(2);
    end else if (32'(frame_height_i) > MAX_HEIGHT) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(frame_height_i);
    end
  end

  assign dims_odd = frame_width_i[0] | frame_height_i[0];
  assign col_last = (32'(col_q) + 32'd1) >= 32'(w_eff);
  assign row_last = (32'(row_q) + 32'd1) >= 32'(h_eff);
  assign in_range = (32'(col_q) >> 1) < LINE_DEPTH;
  assign addr     = AW'(col_q >> 1);

  always_comb begin
    if (!col_q[0]) begin
      pair_d.red   = {1'b0, in_pld_i.red};
      pair_d.green = {1'b0, in_pld_i.green};
      pair_d.blue  = {1'b0, in_pld_i.blue};
    end else begin
      pair_d.red   = pair_q.red + {1'b0, in_pld_i.red};
      pair_d.green = pair_q.green + {1'b0, in_pld_i.green};
      pair_d.blue  = pair_q.blue + {1'b0, in_pld_i.blue};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pair_q <= '0;
    end else if (cmd_i.accept) begin
      if (dims_odd) begin
        col_q  <= '0;
        row_q  <= '0;
        pair_q <= '0;
      end else begin
        pair_q <= pair_d;
        if (col_last) begin
          col_q <= '0;
          row_q <= row_last ? '0 : row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !dims_odd && col_q[0] && !row_q[0] && in_range) begin
      line_mem[addr] <= pair_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      top_q <= line_mem[addr];
      pix_q <= in_pld_i;
      err_q <= dims_odd;
      cv_q  <= !dims_odd && col_q[0] && row_q[0] && in_range;
      eof_q <= !dims_odd && col_last && row_last;
    end
  end

  always_comb begin
    if (matrix_sel_i) begin
      kr  = Kr601;
      kg  = Kg601;
      kb  = Kb601;
      cbr = Cbr601;
      cbg = Cbg601;
      crg = Crg601;
      crb = Crb601;
    end else begin
      kr  = Kr709;
      kg  = Kg709;
      kb  = Kb709;
      cbr = Cbr709;
      cbg = Cbg709;
      crg = Crg709;
      crb = Crb709;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sum) begin
      sr_q  <= {1'b0, top_q.red} + {1'b0, pair_q.red};
      sg_q  <= {1'b0, top_q.green} + {1'b0, pair_q.green};
      sb_q  <= {1'b0, top_q.blue} + {1'b0, pair_q.blue};
      lpr_q <= LPW'(kr) * LPW'(pix_q.red);
      lpg_q <= LPW'(kg) * LPW'(pix_q.green);
      lpb_q <= LPW'(kb) * LPW'(pix_q.blue);
    end
  end

  assign lsum = LSW'(lpr_q) + LSW'(lpg_q) + LSW'(lpb_q) + LumaHalf;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_prod) begin
      luma_q <= sat_u8(lsum[LSW-1:FW]);
      pcbr_q <= PW'(cbr) * PW'(sr_q);
      pcbg_q <= PW'(cbg) * PW'(sg_q);
      pcrg_q <= PW'(crg) * PW'(sg_q);
      pcrb_q <= PW'(crb) * PW'(sb_q);
    end
  end

  assign tcb = (TW'(sb_q) << (FW - 1)) - TW'(pcbr_q) - TW'(pcbg_q) + ChromaOff;
  assign tcr = (TW'(sr_q) << (FW - 1)) - TW'(pcrg_q) - TW'(pcrb_q) + ChromaOff;
  assign cb  = tcb[TW-1] ? 8'd0 : sat_u8({1'b0, tcb[TW-2:FW+2]});
  assign cr  = tcr[TW-1] ? 8'd0 : sat_u8({1'b0, tcr[TW-2:FW+2]});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.luma         <= err_q ? 8'd0 : luma_q;
      out_q.chroma_valid <= cv_q;
      out_q.blue_diff    <= cv_q ? cb : 8'd0;
      out_q.red_diff     <= cv_q ? cr : 8'd0;
      out_q.end_of_frame <= eof_q;
      out_q.dims_error   <= err_q;
    end
  end

  assign out_pld_o = out_q;

endmodule
